FILE: rtl/hbs_pkg.sv
// Package for the heightmap barycentric sampler: item structs, grid sizing,
// register indexes, controller states and the divider step function.
// No dependencies; imported by heightmap_barycentric_sampler_core.
package hbs_pkg;

    // Grid of vertex heights, GRID_VERTS x GRID_VERTS entries
    localparam int GRID_VERTS = 65;
    localparam int GRID_DEPTH = GRID_VERTS * GRID_VERTS;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);

    // Accumulator for the weighted sum of three Q16.16 heights
    localparam int ACC_W = 50;

    // Configuration register indexes (byte address / 4)
    localparam logic [1:0] REG_ORIGIN_X   = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Z   = 2'd1;
    localparam logic [1:0] REG_BLOCK_SIZE = 2'd2;
    localparam logic [1:0] REG_CELL_SIZE  = 2'd3;

    // Input item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic              action;
        logic signed [31:0] query_x;
        logic signed [31:0] query_z;
        logic [6:0]        vertex_col;
        logic [6:0]        vertex_row;
        logic signed [31:0] vertex_height;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] height;
        logic              outside;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_MAC,
        ST_OUT
    } state_t;

    // One restoring division step: returns {new remainder, quotient bit}
    function automatic logic [16:0] div_step(input logic [15:0] rem,
                                             input logic        nbit,
                                             input logic [15:0] dvs);
        logic [16:0] trial;
        logic [16:0] diff;
        trial = {rem, nbit};
        diff  = trial - {1'b0, dvs};
        if (trial >= {1'b0, dvs}) begin
            return {diff[15:0], 1'b1};
        end else begin
            return {trial[15:0], 1'b0};
        end
    endfunction

endpackage

FILE: rtl/heightmap_barycentric_sampler_core.sv
// Heightmap sampler core: vertex height memory, radix-4 cell divider and
// serial multiply-accumulate for barycentric interpolation.
// Depends on hbs_pkg.
//
//  channel   ports                         direction  moves
//  --------  ----------------------------  ---------  --------------------------
//  s_        s_valid s_ready s_item        in         write or query item
//  m_        m_valid m_ready m_item        out        height and outside flag
//  APB       psel penable pwrite paddr ..  in/out     origin, block and cell size
//
// A write item is taken in idle and gives no result. An outside query goes from
// idle straight to the output state; an inside query passes through the
// two-bit-per-cycle divider, corner setup, three serial reads of the single
// memory port through the multiply-accumulate and the output state, which
// forms the result. One item is in work at a time; the next is accepted while a
// finished result waits on m_.
// Reset clears control state and configuration registers; the height memory is not cleared.
module heightmap_barycentric_sampler_core
    import hbs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [15:0] GV_MAX  = 16'(GRID_VERTS - 1);
    localparam logic [16:0] W_ONE   = 17'h10000;
    localparam logic [1:0]  ISSUE_N = 2'd3;

    // Configuration registers
    logic signed [31:0] origin_x_reg;
    logic signed [31:0] origin_z_reg;
    logic [15:0]        block_size_reg;
    logic [15:0]        cell_size_reg;

    // Control
    state_t      state_reg, state_next;
    logic [3:0]  div_cnt_reg;
    logic [1:0]  issue_cnt_reg;
    logic        rd_v_reg;
    logic        mul_v_reg;
    logic        outside_reg;
    logic        m_valid_reg;
    out_item_t   m_item_reg;

    // Datapath
    logic [15:0]        div_d_reg;
    logic [15:0]        rem_x_reg, rem_z_reg;
    logic [31:0]        quo_x_reg, quo_z_reg;
    logic [ADDR_W-1:0]  addr_reg [3];
    logic [16:0]        wt_reg   [3];
    logic [16:0]        wt_d_reg;
    logic signed [31:0] rdata_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    // Height memory
    logic [31:0] mem [GRID_DEPTH];

    logic               accept;
    logic               cfg_wr;
    logic               load_out;
    logic signed [32:0] tx, tz;
    logic [23:0]        lim;
    logic               query_out;
    logic               wr_in_grid;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [16:0]        sx1, sx2, sz1, sz2;
    logic [15:0]        gx, gz, u, v;
    logic [15:0]        c0, c1, r0, r1;
    logic [16:0]        uv_sum;
    logic               lower_tri;
    logic [ADDR_W-1:0]  a00, a10, a01, a11;
    logic signed [ACC_W-1:0] rnd;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid & s_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Read back configuration
    always_comb begin
        case (paddr[3:2])
            REG_ORIGIN_X:   prdata = origin_x_reg;
            REG_ORIGIN_Z:   prdata = origin_z_reg;
            REG_BLOCK_SIZE: prdata = {16'd0, block_size_reg};
            REG_CELL_SIZE:  prdata = {16'd0, cell_size_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg   <= '0;
            origin_z_reg   <= '0;
            block_size_reg <= 16'd64;
            cell_size_reg  <= 16'd1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ORIGIN_X:   origin_x_reg   <= pwdata;
                REG_ORIGIN_Z:   origin_z_reg   <= pwdata;
                REG_BLOCK_SIZE: block_size_reg <= pwdata[15:0];
                REG_CELL_SIZE:  cell_size_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Translate to terrain space and test the bounds
    assign tx        = {s_item.query_x[31], s_item.query_x} - {origin_x_reg[31], origin_x_reg};
    assign tz        = {s_item.query_z[31], s_item.query_z} - {origin_z_reg[31], origin_z_reg};
    assign lim       = {block_size_reg, 8'd0};
    assign query_out = tx[32] || tz[32] || (tx >= $signed({9'd0, lim}))
                       || (tz >= $signed({9'd0, lim}));

    // Vertex write straight from the input item, dropped when off the grid
    assign wr_in_grid = (32'(s_item.vertex_col) < GRID_VERTS)
                        && (32'(s_item.vertex_row) < GRID_VERTS);
    assign mem_we     = accept && (s_item.action == ACT_WRITE) && wr_in_grid;
    assign mem_waddr  = ADDR_W'(s_item.vertex_col) * ADDR_W'(GRID_VERTS)
                        + ADDR_W'(s_item.vertex_row);
    assign mem_raddr  = addr_reg[issue_cnt_reg];

    // Memory: one write port, one registered read port. Writes happen only in idle
    // and reads are issued only while a query is in the multiply-accumulate state, so they never overlap.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= s_item.vertex_height;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Two restoring steps per cycle on each axis
    always_comb begin
        sx1 = div_step(rem_x_reg, quo_x_reg[31], div_d_reg);
        sx2 = div_step(sx1[16:1], quo_x_reg[30], div_d_reg);
        sz1 = div_step(rem_z_reg, quo_z_reg[31], div_d_reg);
        sz2 = div_step(sz1[16:1], quo_z_reg[30], div_d_reg);
    end

    // Cell corners, fractions and triangle weights
    always_comb begin
        gx        = quo_x_reg[31:16];
        u         = quo_x_reg[15:0];
        gz        = quo_z_reg[31:16];
        v         = quo_z_reg[15:0];
        c0        = (gx > GV_MAX) ? GV_MAX : gx;
        c1        = (gx >= GV_MAX) ? GV_MAX : gx + 16'd1;
        r0        = (gz > GV_MAX) ? GV_MAX : gz;
        r1        = (gz >= GV_MAX) ? GV_MAX : gz + 16'd1;
        a00       = ADDR_W'(c0) * ADDR_W'(GRID_VERTS) + ADDR_W'(r0);
        a10       = ADDR_W'(c1) * ADDR_W'(GRID_VERTS) + ADDR_W'(r0);
        a01       = ADDR_W'(c0) * ADDR_W'(GRID_VERTS) + ADDR_W'(r1);
        a11       = ADDR_W'(c1) * ADDR_W'(GRID_VERTS) + ADDR_W'(r1);
        uv_sum    = {1'b0, u} + {1'b0, v};
        lower_tri = (uv_sum <= W_ONE);
    end

    // Round to nearest, ties upward
    assign rnd = acc_reg + ACC_W'(32768);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (s_item.action == ACT_QUERY)) begin
                    state_next = query_out ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == 4'd15) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: state_next = ST_MAC;
            ST_MAC: begin
                if ((issue_cnt_reg == ISSUE_N) && !rd_v_reg && !mul_v_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control counters and pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg   <= '0;
            issue_cnt_reg <= '0;
            rd_v_reg      <= 1'b0;
            mul_v_reg     <= 1'b0;
            outside_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                div_cnt_reg <= '0;
                outside_reg <= query_out;
            end else if (state_reg == ST_DIV) begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            if (state_reg == ST_PREP) begin
                issue_cnt_reg <= '0;
            end else if ((state_reg == ST_MAC) && (issue_cnt_reg != ISSUE_N)) begin
                issue_cnt_reg <= issue_cnt_reg + 2'd1;
            end
            rd_v_reg  <= (state_reg == ST_MAC) && (issue_cnt_reg != ISSUE_N);
            mul_v_reg <= rd_v_reg;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Divider, corner setup and multiply-accumulate
    always_ff @(posedge aclk) begin
        if (accept) begin
            div_d_reg <= (cell_size_reg == 16'd0) ? 16'd1 : cell_size_reg;
            rem_x_reg <= '0;
            rem_z_reg <= '0;
            quo_x_reg <= {tx[23:0], 8'd0};
            quo_z_reg <= {tz[23:0], 8'd0};
        end else if (state_reg == ST_DIV) begin
            rem_x_reg <= sx2[16:1];
            rem_z_reg <= sz2[16:1];
            quo_x_reg <= {quo_x_reg[29:0], sx1[0], sx2[0]};
            quo_z_reg <= {quo_z_reg[29:0], sz1[0], sz2[0]};
        end
        if (state_reg == ST_PREP) begin
            acc_reg     <= '0;
            addr_reg[2] <= a01;
            if (lower_tri) begin
                addr_reg[0] <= a00;
                addr_reg[1] <= a10;
                wt_reg[0]   <= W_ONE - uv_sum;
                wt_reg[1]   <= {1'b0, u};
                wt_reg[2]   <= {1'b0, v};
            end else begin
                addr_reg[0] <= a10;
                addr_reg[1] <= a11;
                wt_reg[0]   <= W_ONE - {1'b0, v};
                wt_reg[1]   <= uv_sum - W_ONE;
                wt_reg[2]   <= W_ONE - {1'b0, u};
            end
        end else if (mul_v_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
        wt_d_reg <= wt_reg[issue_cnt_reg];
        prod_reg <= $signed({1'b0, wt_d_reg}) * rdata_reg;
        if (load_out) begin
            m_item_reg.outside <= outside_reg;
            m_item_reg.height  <= outside_reg ? 32'sd0 : rnd[47:16];
        end
    end

    // Pipeline drained before the result is formed
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> (!rd_v_reg && !mul_v_reg))
        else $error("multiply pipeline busy while forming result");

    // A write item starts no query work
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_item.action == ACT_WRITE)) |=> (state_reg == ST_IDLE))
        else $error("write item left the idle state");

    // Outside results carry zero height
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.outside) |-> (m_item.height == 32'sd0))
        else $error("outside result with nonzero height");

    // Reads are issued only for the three triangle corners, so none is in flight during division
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (issue_cnt_reg == ISSUE_N || !rd_v_reg))
        else $error("memory read in flight during division");

endmodule
